@@ hdl/cascade_incremental_pid_motor_assert.svh @@
// Assertion macros for the motor controller.
`ifndef CASCADE_INCREMENTAL_PID_MOTOR_ASSERT_SVH
`define CASCADE_INCREMENTAL_PID_MOTOR_ASSERT_SVH
`ifndef SYNTH
`define CIPM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CIPM_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CIPM_ASSERT(label, clk, rst, prop, msg)
`define CIPM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ hdl/cipm_pkg.sv @@
// ----------------------------------------------------------------------------
// cipm_pkg
// Shared constants and types of the cascade PID motor controller.
// ----------------------------------------------------------------------------
package cipm_pkg;
  localparam int NUM_MOTORS_DEF = 4;
  localparam int COUNTS_PER_TURN_DEF = 8192;
  localparam int SPEED_I_LIMIT_DEF = 16384;
  localparam int POS_I_LIMIT_DEF = 9600;

  localparam int AW = 3;
  localparam logic [AW-1:0] REG_MODES = 3'd0;
  localparam logic [AW-1:0] REG_SKP = 3'd1;
  localparam logic [AW-1:0] REG_SKI = 3'd2;
  localparam logic [AW-1:0] REG_SKD = 3'd3;
  localparam logic [AW-1:0] REG_PKP = 3'd4;
  localparam logic [AW-1:0] REG_PKI = 3'd5;
  localparam logic [AW-1:0] REG_SMAX = 3'd6;
  localparam logic [AW-1:0] REG_PMAX = 3'd7;

  localparam logic [1:0] MODE_SPEED = 2'd1;
  localparam logic [1:0] MODE_POS = 2'd2;

  // multiplier width: 24-bit gain by 64-bit signed operand
  localparam int MW = 64;
  localparam int PW = MW + 25;

  typedef struct packed {
    logic start;
    logic [23:0] gain;
    logic signed [MW-1:0] opnd;
  } mul_req_t;
endpackage

@@ hdl/cascade_incremental_pid_motor.sv @@
// Order of states: position mode runs UNWRAP, PP, PI, PACC, SERR, SP, SI, SD, SACC, OUT;
//   speed mode skips PP to PACC, no loop goes from UNWRAP to OUT; each serial multiply
//   has a start, one step per gain bit over the 24 gain bits, and a collect step.
// One item at a time; the next input is taken only after the output transfer, once idle.
// Output currents are registered and held until taken; in_ready low while busy.
// Reset (synchronous, rst high) clears all loop state and loads register defaults.
// ----------------------------------------------------------------------------
// cascade_incremental_pid_motor
// Four-motor cascade position/speed incremental PID with APB configuration.
// ----------------------------------------------------------------------------
module cascade_incremental_pid_motor #(
  parameter int NUM_MOTORS = cipm_pkg::NUM_MOTORS_DEF,
  parameter int COUNTS_PER_TURN = cipm_pkg::COUNTS_PER_TURN_DEF,
  parameter int SPEED_I_LIMIT = cipm_pkg::SPEED_I_LIMIT_DEF,
  parameter int POS_I_LIMIT = cipm_pkg::POS_I_LIMIT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] motor_index,
  input  logic [12:0] raw_angle,
  input  logic signed [15:0] speed_meas,
  input  logic signed [31:0] target,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] current_0,
  output logic signed [15:0] current_1,
  output logic signed [15:0] current_2,
  output logic signed [15:0] current_3
);
  localparam int MW = cipm_pkg::MW;
  localparam int PW = cipm_pkg::PW;
  localparam logic signed [MW-1:0] CPT = MW'(COUNTS_PER_TURN);
  localparam logic signed [MW-1:0] SILIM = MW'(SPEED_I_LIMIT) <<< 16;
  localparam logic signed [MW-1:0] PILIM = MW'(POS_I_LIMIT) <<< 16;
  localparam logic signed [MW-1:0] E34MAX = (MW'(1) <<< 33) - MW'(1);
  localparam logic signed [MW-1:0] E34MIN = -(MW'(1) <<< 33);

  // state codes
  localparam logic [3:0] S_IDLE = 4'd0, S_UNWRAP = 4'd1, S_PP = 4'd2,
    S_PI = 4'd3, S_PACC = 4'd4, S_SERR = 4'd5, S_SP = 4'd6, S_SI = 4'd7,
    S_SD = 4'd8, S_SACC = 4'd9, S_OUT = 4'd10, S_WAIT = 4'd11;

  // configuration registers
  logic [7:0] motor_modes;
  logic [23:0] speed_kp, speed_ki, speed_kd, pos_kp, pos_ki;
  logic [14:0] speed_out_max, pos_out_max;
  logic [cipm_pkg::AW-1:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_modes <= 8'd160;
      speed_kp <= 24'd1572864;
      speed_ki <= 24'd78643;
      speed_kd <= 24'd1311;
      pos_kp <= 24'd52429;
      pos_ki <= 24'd197;
      speed_out_max <= 15'd8000;
      pos_out_max <= 15'd9600;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        cipm_pkg::REG_MODES: motor_modes <= pwdata[7:0];
        cipm_pkg::REG_SKP: speed_kp <= pwdata[23:0];
        cipm_pkg::REG_SKI: speed_ki <= pwdata[23:0];
        cipm_pkg::REG_SKD: speed_kd <= pwdata[23:0];
        cipm_pkg::REG_PKP: pos_kp <= pwdata[23:0];
        cipm_pkg::REG_PKI: pos_ki <= pwdata[23:0];
        cipm_pkg::REG_SMAX: speed_out_max <= pwdata[14:0];
        cipm_pkg::REG_PMAX: pos_out_max <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      cipm_pkg::REG_MODES: prdata = {24'd0, motor_modes};
      cipm_pkg::REG_SKP: prdata = {8'd0, speed_kp};
      cipm_pkg::REG_SKI: prdata = {8'd0, speed_ki};
      cipm_pkg::REG_SKD: prdata = {8'd0, speed_kd};
      cipm_pkg::REG_PKP: prdata = {8'd0, pos_kp};
      cipm_pkg::REG_PKI: prdata = {8'd0, pos_ki};
      cipm_pkg::REG_SMAX: prdata = {17'd0, speed_out_max};
      cipm_pkg::REG_PMAX: prdata = {17'd0, pos_out_max};
      default: prdata = '0;
    endcase
  end

  // per-motor state
  logic [12:0] prev_ang [NUM_MOTORS];
  logic [31:0] turn [NUM_MOTORS];
  logic signed [32:0] pe1 [NUM_MOTORS];
  logic signed [32:0] pe2 [NUM_MOTORS];
  logic signed [31:0] pacc [NUM_MOTORS];
  logic signed [33:0] se1 [NUM_MOTORS];
  logic signed [33:0] se2 [NUM_MOTORS];
  logic signed [31:0] sacc [NUM_MOTORS];

  localparam int MIW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  logic [3:0] state;
  logic [MIW-1:0] mi;
  logic [1:0] mode;
  logic [12:0] ang;
  logic signed [15:0] spd;
  logic signed [31:0] tgt;
  logic signed [MW-1:0] err, sum;
  logic signed [PW-1:0] tshr;
  cipm_pkg::mul_req_t req;
  logic mbusy, mwait;
  logic signed [PW-1:0] prod;

  cipm_serial_mul u_mul (.clk(clk), .rst(rst), .req(req), .busy(mbusy), .prod(prod));

  // unwrap delta
  logic signed [MW-1:0] r1, r2, a1, a2, dl, lastv, angv;
  assign lastv = MW'(prev_ang[mi]);
  assign angv = MW'(ang);
  always_comb begin
    r1 = (angv < lastv) ? angv + CPT - lastv : angv - CPT - lastv;
    r2 = angv - lastv;
    a1 = r1[MW-1] ? -r1 : r1;
    a2 = r2[MW-1] ? -r2 : r2;
    dl = (a1 < a2) ? r1 : r2;
  end

  // floor shift of the product (arith shift is floor)
  assign tshr = prod >>> 16;
  logic signed [MW-1:0] term;
  assign term = (state == S_PP || state == S_PI) ? MW'(prod) : MW'(tshr);

  logic signed [MW-1:0] ilim, icl, omax, accn, acl, spt, se_raw;
  assign ilim = (state == S_PI) ? PILIM : SILIM;
  assign icl = (term > ilim) ? ilim : ((term < -ilim) ? -ilim : term);
  assign omax = (state == S_PACC) ? (MW'(pos_out_max) <<< 16) : (MW'(speed_out_max) <<< 16);
  assign accn = ((state == S_PACC) ? MW'(pacc[mi]) : MW'(sacc[mi])) + sum;
  assign acl = (accn > omax) ? omax : ((accn < -omax) ? -omax : accn);
  assign spt = (mode == cipm_pkg::MODE_POS) ? MW'(pacc[mi]) : (MW'(tgt) <<< 16);
  assign se_raw = spt - (MW'(spd) <<< 16);

  assign in_ready = (state == S_IDLE);

  // operand for each multiply
  always_comb begin
    req.start = 1'b0;
    req.gain = '0;
    req.opnd = '0;
    if (!mwait) begin
      unique case (state)
        S_PP: begin req.start = 1'b1; req.gain = pos_kp; req.opnd = err - MW'(pe1[mi]); end
        S_PI: begin req.start = 1'b1; req.gain = pos_ki; req.opnd = err; end
        S_SP: begin req.start = 1'b1; req.gain = speed_kp; req.opnd = err - MW'(se1[mi]); end
        S_SI: begin req.start = 1'b1; req.gain = speed_ki; req.opnd = err; end
        S_SD: begin
          req.start = 1'b1; req.gain = speed_kd;
          req.opnd = err - (MW'(se1[mi]) <<< 1) + MW'(se2[mi]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mwait <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < NUM_MOTORS; k++) begin
        prev_ang[k] <= '0; turn[k] <= '0; pe1[k] <= '0; pe2[k] <= '0;
        pacc[k] <= '0; se1[k] <= '0; se2[k] <= '0; sacc[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          ang <= raw_angle; spd <= speed_meas; tgt <= target;
          mi <= MIW'(motor_index);
          mode <= motor_modes[2*motor_index +: 2];
          state <= (32'(motor_index) < NUM_MOTORS) ? S_UNWRAP : S_OUT;
        end
        S_UNWRAP: begin
          turn[mi] <= turn[mi] + dl[31:0];
          prev_ang[mi] <= ang;
          err <= MW'(tgt) - MW'($signed(turn[mi] + dl[31:0]));
          sum <= '0;
          if (mode == cipm_pkg::MODE_POS) state <= S_PP;
          else if (mode == cipm_pkg::MODE_SPEED) state <= S_SERR;
          else state <= S_OUT;
        end
        S_PP, S_PI, S_SP, S_SI, S_SD: begin
          if (!mwait) mwait <= 1'b1;
          else if (!mbusy && !req.start) begin
            mwait <= 1'b0;
            if (state == S_PI || state == S_SI) sum <= sum + icl;
            else sum <= sum + term;
            unique case (state)
              S_PP: state <= S_PI;
              S_PI: state <= S_PACC;
              S_SP: state <= S_SI;
              S_SI: state <= S_SD;
              default: state <= S_SACC;
            endcase
          end
        end
        S_PACC: begin
          pacc[mi] <= acl[31:0];
          pe2[mi] <= pe1[mi];
          pe1[mi] <= err[32:0];
          state <= S_SERR;
        end
        S_SERR: begin
          sum <= '0;
          if (mode == cipm_pkg::MODE_POS) err <= se_raw;
          else err <= (se_raw > E34MAX) ? E34MAX : ((se_raw < E34MIN) ? E34MIN : se_raw);
          state <= S_SP;
        end
        S_SACC: begin
          sacc[mi] <= acl[31:0];
          se2[mi] <= se1[mi];
          se1[mi] <= err[33:0];
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // integer part of each speed accumulator, truncated toward zero
  logic signed [15:0] cur [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k < NUM_MOTORS) begin
        logic signed [31:0] a;
        logic [31:0] n;
        a = sacc[k % NUM_MOTORS];
        n = 32'(-a);
        cur[k] = a[31] ? 16'(-$signed({1'b0, n[31:16]})) : a[31:16];
      end else begin
        cur[k] = '0;
      end
    end
  end
  assign current_0 = cur[0];
  assign current_1 = cur[1];
  assign current_2 = cur[2];
  assign current_3 = cur[3];

  `include "cascade_incremental_pid_motor_assert.svh"
  `CIPM_ASSERT(a_rdy, clk, rst, out_valid |-> !in_ready, "input taken with output pending")
  `CIPM_ASSERT(a_hold, clk, rst, (out_valid && !out_ready) |=> out_valid, "output dropped")
  `CIPM_ASSERT(a_mul, clk, rst, mbusy |-> !in_ready, "multiplier busy while idle")
endmodule

@@ hdl/cipm_serial_mul.sv @@
// ----------------------------------------------------------------------------
// cipm_serial_mul
// Bit-serial multiply: unsigned 24-bit gain by signed operand,
// one gain bit per cycle.
// ----------------------------------------------------------------------------
module cipm_serial_mul (
  input  logic clk,
  input  logic rst,
  input  cipm_pkg::mul_req_t req,
  output logic busy,
  output logic signed [cipm_pkg::PW-1:0] prod
);
  logic [23:0] gsh;
  logic signed [cipm_pkg::PW-1:0] msh;
  logic [4:0] cnt;

  // shift-and-add, gain shifted right, operand shifted left
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 5'd24;
      gsh <= req.gain;
      msh <= cipm_pkg::PW'(req.opnd);
      prod <= '0;
    end else if (busy) begin
      if (gsh[0]) prod <= prod + msh;
      gsh <= gsh >> 1;
      msh <= msh <<< 1;
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end

  `include "cascade_incremental_pid_motor_assert.svh"
  `CIPM_ASSERT(a_cnt, clk, rst, busy |-> cnt != 5'd0, "serial mul count lost")
  `CIPM_ASSERT(a_idle, clk, rst, !busy |=> (busy == $past(req.start)), "mul start mismatch")
  `CIPM_ASSERT_RST(a_rst, clk, $past(rst) |-> !busy, "mul busy after reset")
endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-motor cascade PID controller. A built-in
// predictor tracks angle unwrapping and both loops per motor. It checks all
// four current commands of every result under random idling, long receiver
// hold-off and several register settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam longint ERR34_HI = 64'sd8589934591;
  localparam longint ERR34_LO = -64'sd8589934592;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 250;

  typedef struct {
    logic signed [15:0] cur [4];
  } currents_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic [1:0] motor_index;
  logic [12:0] raw_angle;
  logic signed [15:0] speed_meas;
  logic signed [31:0] target;
  logic out_valid, out_ready;
  logic signed [15:0] current_0, current_1, current_2, current_3;

  cascade_incremental_pid_motor i_dut (.*);

  // predictor copy of registers and loop state
  bit [7:0]  cfg_modes;
  bit [23:0] cfg_skp, cfg_ski, cfg_skd, cfg_pkp, cfg_pki;
  bit [14:0] cfg_smax, cfg_pmax;
  int        prev_raw [4];
  bit [31:0] turns [4];
  longint    pos_hist [8], pos_acc [4], spd_hist [8], spd_acc [4];

  currents_t expected_currents [$];
  int mismatches, transfers_in, transfers_out, cycle_count;
  int tx_idle_pct, rx_idle_pct, hold_cycles;

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls plus requested long hold-off
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    currents_t exp_c;
    logic signed [15:0] got [4];
    if (!rst && out_valid && out_ready) begin
      transfers_out++;
      got = '{current_0, current_1, current_2, current_3};
      if (expected_currents.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer at %0t", $realtime);
      end else begin
        exp_c = expected_currents.pop_front();
        for (int k = 0; k < 4; k++)
          if (got[k] !== exp_c.cur[k]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("current_%0d mismatch at %0t: expected %0d, got %0d",
                       k, $realtime, exp_c.cur[k], got[k]);
          end
      end
    end
  end

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one velocity-form step; q16 scales the products back by 2^16 (floor)
  function automatic void pid_update(input longint e, inout longint h0, inout longint h1,
                                     inout longint acc, input longint kp, input longint ki,
                                     input longint kd, input longint ilim,
                                     input longint omax, input bit q16);
    longint p, i, d;
    p = kp * (e - h0);
    i = ki * e;
    d = kd * (e - 2 * h0 + h1);
    if (q16) begin
      p = p >>> 16;
      i = i >>> 16;
      d = d >>> 16;
    end
    i = clamp_mag(i, ilim * 65536);
    acc = clamp_mag(acc + p + i + d, omax * 65536);
    h1 = h0;
    h0 = e;
  endfunction

  // advance the controller by one feedback sample, return the four commands
  function automatic currents_t control_step(bit [1:0] m, bit [12:0] ang,
                                             logic signed [15:0] spd,
                                             logic signed [31:0] tgt);
    currents_t r;
    int r1, r2, delta;
    bit [1:0] mode;
    longint sp, se, a;
    mode = cfg_modes[2*m +: 2];
    if (ang < prev_raw[m]) r1 = ang + cipm_pkg::COUNTS_PER_TURN_DEF - prev_raw[m];
    else r1 = ang - cipm_pkg::COUNTS_PER_TURN_DEF - prev_raw[m];
    r2 = ang - prev_raw[m];
    delta = ((r1 < 0 ? -r1 : r1) < (r2 < 0 ? -r2 : r2)) ? r1 : r2;
    turns[m] = turns[m] + 32'(delta);
    prev_raw[m] = ang;
    if (mode == cipm_pkg::MODE_SPEED || mode == cipm_pkg::MODE_POS) begin
      if (mode == cipm_pkg::MODE_POS) begin
        pid_update(longint'(tgt) - longint'($signed(turns[m])), pos_hist[2*m],
                   pos_hist[2*m+1], pos_acc[m], cfg_pkp, cfg_pki, 0,
                   cipm_pkg::POS_I_LIMIT_DEF, cfg_pmax, 1'b0);
        sp = pos_acc[m];
      end else begin
        sp = longint'(tgt) * 65536;
      end
      se = sp - longint'(spd) * 65536;
      if (se > ERR34_HI) se = ERR34_HI;
      if (se < ERR34_LO) se = ERR34_LO;
      pid_update(se, spd_hist[2*m], spd_hist[2*m+1], spd_acc[m], cfg_skp, cfg_ski,
                 cfg_skd, cipm_pkg::SPEED_I_LIMIT_DEF, cfg_smax, 1'b1);
    end
    for (int k = 0; k < 4; k++) begin
      a = spd_acc[k];
      r.cur[k] = 16'((a >= 0) ? (a >>> 16) : -((-a) >>> 16));
    end
    return r;
  endfunction

  // send one feedback sample; entered and left at a falling edge
  task automatic send_sample(bit [1:0] m, bit [12:0] ang, logic signed [15:0] spd,
                             logic signed [31:0] tgt);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    motor_index = m;
    raw_angle = ang;
    speed_meas = spd;
    target = tgt;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    expected_currents.push_back(control_step(m, ang, spd, tgt));
    transfers_in++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 0;
    while (expected_currents.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write, block idle; entered and left at a falling edge
  task automatic write_reg(logic [cipm_pkg::AW-1:0] idx, bit [31:0] val);
    psel = 1; pwrite = 1; penable = 0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    unique case (idx)
      cipm_pkg::REG_MODES: cfg_modes = val[7:0];
      cipm_pkg::REG_SKP:   cfg_skp = val[23:0];
      cipm_pkg::REG_SKI:   cfg_ski = val[23:0];
      cipm_pkg::REG_SKD:   cfg_skd = val[23:0];
      cipm_pkg::REG_PKP:   cfg_pkp = val[23:0];
      cipm_pkg::REG_PKI:   cfg_pki = val[23:0];
      cipm_pkg::REG_SMAX:  cfg_smax = val[14:0];
      cipm_pkg::REG_PMAX:  cfg_pmax = val[14:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // random sample shaped by the motor's mode; mostly plausible, some full range
  task automatic send_random;
    bit [1:0] m;
    bit [12:0] ang;
    logic signed [15:0] spd;
    logic signed [31:0] tgt;
    m = 2'($urandom_range(3));
    if ($urandom_range(9) < 7) ang = 13'(prev_raw[m] + $urandom_range(0, 1200) - 600);
    else ang = 13'($urandom);
    spd = ($urandom_range(9) < 8) ? 16'($urandom_range(0, 8000) - 4000) : 16'($urandom);
    if ($urandom_range(9) == 0) tgt = $urandom;
    else if (cfg_modes[2*m +: 2] == cipm_pkg::MODE_POS)
      tgt = $signed(turns[m]) + $urandom_range(0, 40000) - 20000;
    else tgt = $urandom_range(0, 12000) - 6000;
    send_sample(m, ang, spd, tgt);
  endtask

  task automatic random_settings;
    write_reg(cipm_pkg::REG_MODES, $urandom);
    write_reg(cipm_pkg::REG_SKP,
              $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 4000000));
    write_reg(cipm_pkg::REG_SKI,
              $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 200000));
    write_reg(cipm_pkg::REG_SKD,
              $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 20000));
    write_reg(cipm_pkg::REG_PKP,
              $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 200000));
    write_reg(cipm_pkg::REG_PKI,
              $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 2000));
    write_reg(cipm_pkg::REG_SMAX, $urandom_range(0, 32767));
    write_reg(cipm_pkg::REG_PMAX, $urandom_range(0, 32767));
  endtask

  // field extremes, every mode, wrap in both directions
  task automatic test_directed;
    write_reg(cipm_pkg::REG_MODES,
              {MODE_SPARE, cipm_pkg::MODE_POS, cipm_pkg::MODE_SPEED, MODE_OFF});
    send_sample(2'd1, 13'd8191, 16'sd0, 32'sd1000);
    send_sample(2'd2, 13'd100, 16'sd0, 32'sd50000);
    send_sample(2'd0, 13'd4096, 16'sd10, 32'sd500);
    send_sample(2'd3, 13'd4097, -16'sd10, -32'sd500);
    send_sample(2'd1, 13'd10, 16'sh7fff, 32'sh7fffffff);
    send_sample(2'd1, 13'd8180, -16'sh8000, -32'sh80000000);
    send_sample(2'd1, 13'd0, -16'sh8000, 32'sh7fffffff);
    send_sample(2'd1, 13'd4095, 16'sh7fff, -32'sh80000000);
    send_sample(2'd2, 13'd8191, 16'sd300, -32'sd70000);
    send_sample(2'd2, 13'd0, -16'sd300, 32'sh7fffffff);
    send_sample(2'd2, 13'd4096, 16'sd0, -32'sh80000000);
    send_sample(2'd2, 13'd4095, 16'sd0, 32'sd0);
    send_sample(2'd0, 13'd8191, 16'sh7fff, 32'sh7fffffff);
    send_sample(2'd3, 13'd0, -16'sh8000, -32'sh80000000);
    send_sample(2'd2, 13'd6000, 16'sd0, 32'sd100);
    send_sample(2'd1, 13'd1, 16'sd0, 32'sd0);
    drain;
  endtask

  // gains and clamps at their extremes
  task automatic test_setting_extremes;
    write_reg(cipm_pkg::REG_MODES, {4{cipm_pkg::MODE_POS}});
    write_reg(cipm_pkg::REG_SKP, 24'hffffff); write_reg(cipm_pkg::REG_SKI, 24'hffffff);
    write_reg(cipm_pkg::REG_SKD, 24'hffffff); write_reg(cipm_pkg::REG_PKP, 24'hffffff);
    write_reg(cipm_pkg::REG_PKI, 24'hffffff);
    write_reg(cipm_pkg::REG_SMAX, 15'h7fff); write_reg(cipm_pkg::REG_PMAX, 15'h7fff);
    repeat (40) send_random;
    drain;
    write_reg(cipm_pkg::REG_MODES, {4{cipm_pkg::MODE_SPEED}});
    write_reg(cipm_pkg::REG_SMAX, 0); write_reg(cipm_pkg::REG_PMAX, 0);
    write_reg(cipm_pkg::REG_SKP, 0); write_reg(cipm_pkg::REG_SKI, 0);
    write_reg(cipm_pkg::REG_SKD, 0);
    write_reg(cipm_pkg::REG_PKP, 0); write_reg(cipm_pkg::REG_PKI, 0);
    repeat (20) send_random;
    drain;
  endtask

  // random stream in chunks, fresh register setting per chunk
  task automatic test_random_stream(int tx_pct, int rx_pct, int chunks);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int c = 0; c < chunks; c++) begin
      random_settings;
      repeat (100) send_random;
      drain;
    end
  endtask

  // receiver holds off while the sender keeps offering; then a full pause
  task automatic test_backpressure;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_cycles = 600;
    repeat (12) send_random;
    in_valid = 0;
    while (expected_currents.size() != 0) @(negedge clk);
    repeat (12) send_random;
    drain;
  endtask

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; motor_index = 0; raw_angle = 0; speed_meas = 0; target = 0;
    tx_idle_pct = 0; rx_idle_pct = 0; hold_cycles = 0;
    mismatches = 0; transfers_in = 0; transfers_out = 0; cycle_count = 0;
    cfg_modes = 8'd160; cfg_skp = 24'd1572864; cfg_ski = 24'd78643; cfg_skd = 24'd1311;
    cfg_pkp = 24'd52429; cfg_pki = 24'd197; cfg_smax = 15'd8000; cfg_pmax = 15'd9600;
    for (int k = 0; k < 4; k++) begin
      prev_raw[k] = 0; turns[k] = 0; pos_acc[k] = 0; spd_acc[k] = 0;
      pos_hist[2*k] = 0; pos_hist[2*k+1] = 0; spd_hist[2*k] = 0; spd_hist[2*k+1] = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    @(negedge clk);

    // default settings first, then directed and swept
    repeat (30) send_random;
    drain;
    test_directed;
    test_setting_extremes;
    test_backpressure;
    test_random_stream(17, 49, 3);
    test_random_stream(49, 17, 3);
    test_random_stream(0, 0, 2);

    drain;
    $display("Sent %0d samples and checked %0d command sets across all modes,", transfers_in,
             transfers_out);
    $display("gain and clamp extremes, angle wraps and receiver hold-off; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_currents.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hdl
hdl/cipm_pkg.sv
hdl/cipm_serial_mul.sv
hdl/cascade_incremental_pid_motor.sv
verif/testbench.sv
